// ===== src/dps_pkg.sv =====
// shared types and constants for the depth-first path search unit
package dps_pkg;

  localparam int NODE_W      = 4;
  localparam int ROW_W       = 16;
  localparam int STACK_DEPTH = 16;
  localparam int SLOT_W      = 4;
  localparam int CNT_W       = 5;

  // input operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  // stack operations
  typedef enum logic [1:0] {
    STK_HOLD,
    STK_INIT,
    STK_PUSH,
    STK_POP
  } stk_op_t;

  typedef struct packed {
    stk_op_t             op;
    logic [NODE_W-1:0]   node;
  } stk_ctrl_t;

  typedef struct packed {
    logic [NODE_W-1:0]   top;
    logic [CNT_W-1:0]    count;
  } stk_stat_t;

endpackage

// ===== src/dps_pick.sv =====
// lowest-numbered candidate neighbor picker
module dps_pick #(
  parameter int SPAN = 16
) (
  input  logic [SPAN-1:0]             cand,
  output logic                        hit,
  output logic [dps_pkg::NODE_W-1:0]  idx
);

  // priority encoder, lowest set bit wins
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = SPAN - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit = 1'b1;
        idx = dps_pkg::NODE_W'(i);
      end
    end
  end

endmodule

// ===== src/dps_stack.sv =====
// path stack with push, pop and restart
module dps_stack (
  input  logic                clk,
  input  logic                rst,
  input  dps_pkg::stk_ctrl_t  ctrl,
  output dps_pkg::stk_stat_t  stat
);

  logic [dps_pkg::NODE_W-1:0] mem [dps_pkg::STACK_DEPTH];
  logic [dps_pkg::CNT_W-1:0]  count;
  logic [dps_pkg::CNT_W-1:0]  count_m1;

  assign count_m1   = count - dps_pkg::CNT_W'(1);
  assign stat.count = count;
  assign stat.top   = mem[count_m1[dps_pkg::SLOT_W-1:0]];

  // stack depth
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (ctrl.op)
        dps_pkg::STK_INIT: count <= dps_pkg::CNT_W'(1);
        dps_pkg::STK_PUSH: count <= count + dps_pkg::CNT_W'(1);
        dps_pkg::STK_POP:  count <= count_m1;
        default:           count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (ctrl.op == dps_pkg::STK_INIT) begin
      mem[0] <= ctrl.node;
    end else if (ctrl.op == dps_pkg::STK_PUSH) begin
      mem[count[dps_pkg::SLOT_W-1:0]] <= ctrl.node;
    end
  end

endmodule

// ===== src/dfs_path_search_unit.sv =====
// depth-first path search over a loadable adjacency matrix
// a row load is written on its transfer; the block is ready again the next cycle
// a search pushes or pops the path stack, one step at a time
// (one pick of the neighbor priority encoder each cycle), then emits one item per path node
// result items leave one per cycle while out_ready is high, from a single output register
// rst clears the matrix, the visited mask, the stack depth and the output valid
module dfs_path_search_unit #(
  parameter int NODES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [3:0]                  row_index,
  input  logic [15:0]                 row_bits,
  input  logic [3:0]                  start_node,
  input  logic [3:0]                  target_node,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [3:0]                  path_node,
  output logic                        found,
  output logic                        last_of_run
);

  localparam int SPAN   = (NODES < 16) ? NODES : 16;
  localparam int RIDX_W = $clog2(SPAN);
  localparam logic [4:0] SPAN_V = 5'(SPAN);

  dps_pkg::state_t    state, state_next;
  dps_pkg::stk_ctrl_t stk_ctrl;
  dps_pkg::stk_stat_t stk_stat;

  logic [SPAN-1:0]            adjacency [SPAN];
  logic [SPAN-1:0]            visited, visited_next;
  logic [3:0]                 target;
  logic [SPAN-1:0]            cand;
  logic                       pick_hit;
  logic [3:0]                 pick_idx;
  logic                       load_out;
  logic [3:0]                 node_next;
  logic                       found_next;
  logic                       last_next;
  logic                       row_ok;
  logic                       ends_ok;

  assign row_ok  = {1'b0, row_index} < SPAN_V;
  assign ends_ok = ({1'b0, start_node} < SPAN_V) && ({1'b0, target_node} < SPAN_V);
  assign cand    = adjacency[stk_stat.top[RIDX_W-1:0]] & ~visited;

  dps_pick #(.SPAN(SPAN)) u_pick (
    .cand (cand),
    .hit  (pick_hit),
    .idx  (pick_idx)
  );

  dps_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctrl (stk_ctrl),
    .stat (stk_stat)
  );

  // sequencer
  always_comb begin
    state_next    = state;
    stk_ctrl.op   = dps_pkg::STK_HOLD;
    stk_ctrl.node = start_node;
    visited_next  = visited;
    in_ready      = 1'b0;
    load_out      = 1'b0;
    node_next     = '0;
    found_next    = 1'b0;
    last_next     = 1'b1;
    unique case (state)
      dps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && operation == dps_pkg::OP_SEARCH) begin
          visited_next = '0;
          if (ends_ok) begin
            stk_ctrl.op  = dps_pkg::STK_INIT;
            visited_next = SPAN'(1) << start_node[RIDX_W-1:0];
            state_next   = dps_pkg::ST_SEARCH;
          end else begin
            load_out   = 1'b1;
            state_next = dps_pkg::ST_DRAIN;
          end
        end
      end
      dps_pkg::ST_SEARCH: begin
        if (stk_stat.count == '0) begin
          load_out   = 1'b1;
          state_next = dps_pkg::ST_DRAIN;
        end else if (stk_stat.top == target) begin
          state_next = dps_pkg::ST_EMIT;
        end else if (pick_hit && stk_stat.count < dps_pkg::CNT_W'(dps_pkg::STACK_DEPTH)) begin
          stk_ctrl.op   = dps_pkg::STK_PUSH;
          stk_ctrl.node = pick_idx;
          visited_next  = visited | (SPAN'(1) << pick_idx[RIDX_W-1:0]);
        end else begin
          stk_ctrl.op = dps_pkg::STK_POP;
        end
      end
      dps_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out    = 1'b1;
          node_next   = stk_stat.top;
          found_next  = 1'b1;
          last_next   = stk_stat.count == dps_pkg::CNT_W'(1);
          stk_ctrl.op = dps_pkg::STK_POP;
          if (last_next) begin
            state_next = dps_pkg::ST_DRAIN;
          end
        end
      end
      dps_pkg::ST_DRAIN: begin
        if (out_ready) begin
          state_next = dps_pkg::ST_IDLE;
        end
      end
      default: state_next = dps_pkg::ST_IDLE;
    endcase
  end

  // state, visited mask and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dps_pkg::ST_IDLE;
      visited   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      visited <= visited_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload and search target
  always_ff @(posedge clk) begin
    if (load_out) begin
      path_node   <= node_next;
      found       <= found_next;
      last_of_run <= last_next;
    end
    if (in_valid && in_ready) begin
      target <= target_node;
    end
  end

  // adjacency rows, written by load transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < SPAN; r++) begin
        adjacency[r] <= '0;
      end
    end else if (in_valid && in_ready && operation == dps_pkg::OP_LOAD && row_ok) begin
      adjacency[row_index[RIDX_W-1:0]] <= row_bits[SPAN-1:0];
    end
  end

endmodule

// ===== src/dps_checker.sv =====
// port-level checks for the path search unit, bound to the top level
module dps_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  path_node,
  input logic        found,
  input logic        last_of_run
);

  // a failed search gives one closing item with node zero
  a_fail_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last_of_run && path_node == 4'd0)
    else $error("failed search item malformed");

  // no input transfer while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid)
    else $error("input taken while result pending");

  // a load transfer yields no result and frees the input at once
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == dps_pkg::OP_LOAD |=> !out_valid && in_ready)
    else $error("load transfer produced a result or stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(path_node) && $stable(found)
      && $stable(last_of_run))
    else $error("stalled result changed");

endmodule

bind dfs_path_search_unit dps_checker u_dps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .operation   (operation),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .path_node   (path_node),
  .found       (found),
  .last_of_run (last_of_run)
);
